[rtl/mksa_pkg.sv]
// ----------------------------------------------------------------------------
// mksa_pkg
// Shared widths, types and sequencer states of the key-switch accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package mksa_pkg;

  localparam int unsigned COEF_W      = 62;
  localparam int unsigned CNT_W       = 6;
  localparam int unsigned IN_TDATA_W  = 192;
  localparam int unsigned OUT_TDATA_W = 64;

  typedef logic [COEF_W-1:0] coef_t;

  localparam coef_t             MOD_MIN  = coef_t'(2);
  localparam logic [CNT_W-1:0]  BIT_TOP  = CNT_W'(COEF_W - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_PREP,
    ST_MUL,
    ST_SUB,
    ST_FIX
  } st_t;

endpackage

`default_nettype wire

[rtl/modular_keyswitch_accumulate.sv]
// ----------------------------------------------------------------------------
// modular_keyswitch_accumulate
// One key-switch output coefficient: start value minus the sum of key times
// digit over the terms of a run, modulo a configured modulus.
// Input beats are taken one at a time: a new beat is accepted only after the
// previous one has gone through acceptance, bit-serial reduction of key and
// running value, set-up, bit-serial modular multiply (one multiplier bit per
// cycle) and final subtraction. A full output register still waiting stalls
// the final step.
// Reset: synchronous, active low; modulus returns to 2, running value and
// error flag to zero, no result pending.
// ----------------------------------------------------------------------------
`default_nettype none

module modular_keyswitch_accumulate
  import mksa_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // configuration
  input  wire logic                   cfg_wr_en,
  input  wire logic [COEF_W-1:0]      cfg_wr_data,       // modulus
  // input beats
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,  // start_value, key_coeff, digit_coeff, zero pad
  input  wire logic                   in_tuser,  // first_term
  input  wire logic                   in_tlast,  // last_term
  // result beats
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata, // coeff_out, zero pad
  output logic                        out_tuser  // range_error
);

  st_t   state_r, state_nxt;

  coef_t modulus_r;
  coef_t running_value_r;
  logic  error_seen_r;

  coef_t q_r;
  coef_t key_sh_r, run_sh_r, digit_sh_r;
  coef_t key_rem_r, run_rem_r, acc_r;
  logic [COEF_W:0] qa1_r, qa2_r;
  logic [COEF_W:0] diff_r;
  logic [CNT_W-1:0] cnt_r;
  logic  last_r, err_r;

  logic  out_valid_r;
  coef_t out_coeff_r;
  logic  out_err_r;

  coef_t in_start, in_key, in_digit;
  logic  in_fire, fix_go, cnt_done;

  assign in_start = in_tdata[COEF_W-1:0];
  assign in_key   = in_tdata[2*COEF_W-1:COEF_W];
  assign in_digit = in_tdata[3*COEF_W-1:2*COEF_W];

  assign in_fire  = in_tvalid && in_tready;
  assign cnt_done = (cnt_r == '0);
  assign fix_go   = !last_r || !out_valid_r || out_tready;

  // bit-serial reduction: r = 2r + bit, minus q if not below it
  logic [COEF_W:0]   key_cat, run_cat;
  logic [COEF_W+1:0] key_try, run_try;
  coef_t             key_step, run_step;

  assign key_cat  = {key_rem_r, key_sh_r[COEF_W-1]};
  assign run_cat  = {run_rem_r, run_sh_r[COEF_W-1]};
  assign key_try  = {1'b0, key_cat} - {2'b00, q_r};
  assign run_try  = {1'b0, run_cat} - {2'b00, q_r};
  assign key_step = key_try[COEF_W+1] ? key_cat[COEF_W-1:0] : key_try[COEF_W-1:0];
  assign run_step = run_try[COEF_W+1] ? run_cat[COEF_W-1:0] : run_try[COEF_W-1:0];

  // multiply step: v = 2acc + bit*a < 3q, candidates v, v-q, v-2q side by side
  logic              mbit;
  logic [COEF_W+2:0] dbl, add_s, try_1, try_2;
  logic [COEF_W:0]   sub1, sub2;
  coef_t             acc_step;

  assign mbit  = digit_sh_r[COEF_W-1];
  assign sub1  = mbit ? qa1_r : {1'b0, q_r};
  assign sub2  = mbit ? qa2_r : {q_r, 1'b0};
  assign dbl   = {2'b00, acc_r, 1'b0};
  assign add_s = dbl + (mbit ? {3'b000, key_rem_r} : '0);
  assign try_1 = dbl - {2'b00, sub1};
  assign try_2 = dbl - {2'b00, sub2};

  always_comb begin
    if (!try_2[COEF_W+2]) begin
      acc_step = try_2[COEF_W-1:0];
    end else if (!try_1[COEF_W+2]) begin
      acc_step = try_1[COEF_W-1:0];
    end else begin
      acc_step = add_s[COEF_W-1:0];
    end
  end

  // final correction of run - product into [0, q)
  coef_t fixed;
  assign fixed = diff_r[COEF_W] ? (diff_r[COEF_W-1:0] + q_r) : diff_r[COEF_W-1:0];

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          state_nxt = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (cnt_done) begin
          state_nxt = ST_PREP;
        end
      end
      ST_PREP:   state_nxt = ST_MUL;
      ST_MUL: begin
        if (cnt_done) begin
          state_nxt = ST_SUB;
        end
      end
      ST_SUB:    state_nxt = ST_FIX;
      ST_FIX: begin
        if (fix_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // control state and the result handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r       <= MOD_MIN;
      running_value_r <= '0;
      error_seen_r    <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        modulus_r <= (cfg_wr_data < MOD_MIN) ? MOD_MIN : cfg_wr_data;
      end
      if (state_r == ST_FIX && fix_go && last_r) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == ST_FIX && fix_go) begin
        if (last_r) begin
          running_value_r <= '0;
          error_seen_r    <= 1'b0;
        end else begin
          running_value_r <= fixed;
          error_seen_r    <= err_r;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          q_r        <= modulus_r;
          key_sh_r   <= in_key;
          digit_sh_r <= in_digit;
          run_sh_r   <= in_tuser ? in_start : running_value_r;
          key_rem_r  <= '0;
          run_rem_r  <= '0;
          cnt_r      <= BIT_TOP;
          last_r     <= in_tlast;
          err_r      <= (in_tuser ? (in_start >= modulus_r) : error_seen_r)
                        || (in_key >= modulus_r) || (in_digit >= modulus_r);
        end
      end
      ST_REDUCE: begin
        key_rem_r <= key_step;
        run_rem_r <= run_step;
        key_sh_r  <= {key_sh_r[COEF_W-2:0], 1'b0};
        run_sh_r  <= {run_sh_r[COEF_W-2:0], 1'b0};
        cnt_r     <= cnt_r - 1'b1;
      end
      ST_PREP: begin
        qa1_r <= {1'b0, q_r} - {1'b0, key_rem_r};
        qa2_r <= {q_r, 1'b0} - {1'b0, key_rem_r};
        acc_r <= '0;
        cnt_r <= BIT_TOP;
      end
      ST_MUL: begin
        acc_r      <= acc_step;
        digit_sh_r <= {digit_sh_r[COEF_W-2:0], 1'b0};
        cnt_r      <= cnt_r - 1'b1;
      end
      ST_SUB: begin
        diff_r <= {1'b0, run_rem_r} - {1'b0, acc_r};
      end
      ST_FIX: begin
        if (fix_go && last_r) begin
          out_coeff_r <= fixed;
          out_err_r   <= err_r;
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-COEF_W){1'b0}}, out_coeff_r};
  assign out_tuser  = out_err_r;

  // checks
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_tready)
    else $error("second beat taken while an item is in progress");

  a_rem_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PREP) |-> (key_rem_r < q_r) && (run_rem_r < q_r))
    else $error("reduction left a remainder at or above the modulus");

  a_acc_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL) |=> (acc_r < q_r))
    else $error("multiply accumulator left the residue range");

  a_result_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> (out_coeff_r < q_r))
    else $error("result coefficient at or above the modulus");

endmodule

`default_nettype wire

[dv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for modular_keyswitch_accumulate. Terms are streamed as
// runs of beats, and a local model of the modular accumulation predicts each
// coefficient and range flag. Directed cases come first: the reset modulus,
// modulus extremes, run marking, a modulus change inside a run and output
// back-pressure. Random runs follow under three sender/receiver idling mixes.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mksa_pkg::*;

  localparam int    CLK_PERIOD      = 8;
  localparam int    SETTLE_CYCLES   = 160;
  localparam int    HOLD_CYCLES     = 1500;
  localparam int    ITEMS_PER_PHASE = 128;
  localparam int    WIDE_W          = 2 * COEF_W;
  localparam coef_t MOD_MAX         = '1;
  localparam coef_t OPERAND_MAX     = MOD_MAX - coef_t'(1);

  typedef logic [WIDE_W-1:0] wide_t;

  typedef struct packed {
    coef_t coeff;
    logic  range_err;
  } coeff_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   cfg_wr_en;
  logic [COEF_W-1:0]      cfg_wr_data;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // start_value, key_coeff, digit_coeff, zero pad
  logic                   in_tuser;   // first_term
  logic                   in_tlast;   // last_term
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;  // coeff_out, zero pad
  logic                   out_tuser;  // range_error

  // model of the block's state
  coef_t         modulus_now;
  coef_t         acc_value;
  bit            acc_err;
  coeff_result_t expected_coeffs[$];

  int  fail_count = 0;
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  valid_held = 0;
  logic hold_start = 1'b0;
  int  hold_left = 0;

  modular_keyswitch_accumulate u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic coef_t rand_coef();
    return coef_t'({$urandom, $urandom});
  endfunction

  // mostly in range, with edge values and the odd unreduced operand
  function automatic coef_t pick_operand(coef_t q);
    coef_t v;
    v = rand_coef();
    case ($urandom_range(19))
      0:       return coef_t'(0);
      1:       return q - coef_t'(1);
      2:       return OPERAND_MAX;
      3, 4:    return (v == MOD_MAX) ? OPERAND_MAX : v;
      default: return v % q;
    endcase
  endfunction

  function automatic coef_t pick_modulus(int slot, bit smallest);
    coef_t v;
    int    bits;
    v = rand_coef();
    bits = $urandom_range(2, COEF_W);
    case (slot)
      0:       return smallest ? MOD_MIN : coef_t'($urandom_range(2, 40));
      1:       return (v >> (COEF_W - bits)) | (coef_t'(1) << (bits - 1));
      2:       return ($urandom_range(1) != 0) ? MOD_MAX : OPERAND_MAX;
      default: return v;
    endcase
  endfunction

  // one term of the running coefficient: start minus key times digit, mod q
  function automatic void accumulate_term(bit first, coef_t start, coef_t key,
                                          coef_t digit, bit last);
    coef_t         q;
    coef_t         run;
    coef_t         prod;
    bit            err;
    coeff_result_t res;
    q = modulus_now;
    if (first) begin
      err = (start >= q);
      run = start % q;
    end else begin
      err = acc_err;
      run = acc_value % q;
    end
    if (key >= q || digit >= q) err = 1'b1;
    prod = coef_t'((wide_t'(key % q) * wide_t'(digit % q)) % wide_t'(q));
    run = (run >= prod) ? run - prod : run + (q - prod);
    if (last) begin
      res.coeff = run;
      res.range_err = err;
      expected_coeffs.insert(expected_coeffs.size(), res);
      acc_value = '0;
      acc_err = 1'b0;
    end else begin
      acc_value = run;
      acc_err = err;
    end
  endfunction

  task automatic send_term(bit first, coef_t start, coef_t key, coef_t digit, bit last);
    in_tdata  <= IN_TDATA_W'({digit, key, start});
    in_tuser  <= first;
    in_tlast  <= last;
    in_tvalid <= 1'b1;
    valid_held = 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    accumulate_term(first, start, key, digit, last);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      valid_held = 1'b0;
      repeat ($urandom_range(1, 140)) @(posedge clk);
    end
  endtask

  // drain every pending result, then give a non-final term time to finish
  task automatic settle_block();
    if (valid_held) begin
      in_tvalid <= 1'b0;
      valid_held = 1'b0;
    end
    while (expected_coeffs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_modulus(coef_t value);
    settle_block();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    modulus_now = (value < MOD_MIN) ? MOD_MIN : value;
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic test_reset_modulus();
    // modulus is 2 straight out of reset
    send_term(1'b1, coef_t'(1), coef_t'(1), coef_t'(1), 1'b1);
    send_term(1'b1, coef_t'(0), coef_t'(1), coef_t'(1), 1'b1);
    send_term(1'b1, coef_t'(0), coef_t'(0), coef_t'(0), 1'b1);
    send_term(1'b1, OPERAND_MAX, OPERAND_MAX, OPERAND_MAX, 1'b1);
  endtask

  task automatic test_modulus_extremes();
    // zero and one are clamped to two
    write_modulus(coef_t'(0));
    send_term(1'b1, coef_t'(1), coef_t'(3), coef_t'(1), 1'b1);
    write_modulus(coef_t'(1));
    send_term(1'b1, coef_t'(0), coef_t'(1), coef_t'(1), 1'b1);
    write_modulus(MOD_MAX);
    send_term(1'b1, OPERAND_MAX, OPERAND_MAX, OPERAND_MAX, 1'b1);
    send_term(1'b1, coef_t'(0), OPERAND_MAX, coef_t'(1), 1'b1);
    // operands equal to the modulus raise the range flag
    write_modulus(OPERAND_MAX);
    send_term(1'b1, coef_t'(5), OPERAND_MAX, coef_t'(2), 1'b1);
    send_term(1'b1, OPERAND_MAX, coef_t'(1), coef_t'(1), 1'b1);
    write_modulus(coef_t'(3));
    send_term(1'b1, coef_t'(2), coef_t'(2), coef_t'(2), 1'b1);
  endtask

  task automatic test_run_marks();
    write_modulus(coef_t'(1000003));
    // three-term run, flag raised on the middle term only
    send_term(1'b1, coef_t'(12345), coef_t'(999), coef_t'(1000002), 1'b0);
    send_term(1'b0, coef_t'(777), coef_t'(2000000), coef_t'(7), 1'b0);
    send_term(1'b0, coef_t'(0), coef_t'(42), coef_t'(43), 1'b1);
    // no first mark: continues from the cleared state
    send_term(1'b0, coef_t'(500), coef_t'(3), coef_t'(4), 1'b1);
    // first and last on one beat
    send_term(1'b1, coef_t'(10), coef_t'(1000002), coef_t'(1000002), 1'b1);
  endtask

  task automatic test_modulus_mid_run();
    write_modulus(coef_t'(64'h0FFF_FFFF_FFFF_FFC5));
    send_term(1'b1, coef_t'(64'h0FFF_FFFF_0000_0001), coef_t'(123456789),
              coef_t'(987654321), 1'b0);
    // the held partial value is re-reduced under the new modulus
    write_modulus(coef_t'(97));
    send_term(1'b0, coef_t'(0), coef_t'(5), coef_t'(6), 1'b1);
  endtask

  task automatic test_output_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_modulus(pick_modulus(1, 1'b0));
    hold_start <= 1'b1;
    @(posedge clk);
    hold_start <= 1'b0;
    repeat (8)
      send_term(1'b1, pick_operand(modulus_now), pick_operand(modulus_now),
                pick_operand(modulus_now), 1'b1);
  endtask

  task automatic test_random_runs(int send_pct, int recv_pct, bit smallest);
    int sent;
    int len;
    bit skip_first;
    bit skip_last;
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    for (int slot = 0; slot < 4; slot++) begin
      write_modulus(pick_modulus(slot, smallest));
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 4);
        skip_first = ($urandom_range(9) == 0);
        skip_last = ($urandom_range(19) == 0);
        for (int t = 0; t < len; t++) begin
          send_term((t == 0) && !skip_first, pick_operand(modulus_now),
                    pick_operand(modulus_now), pick_operand(modulus_now),
                    (t == len - 1) && !skip_last);
          sent++;
        end
      end
    end
  endtask

  // result side: random stalls, or a long hold-off on request
  always @(posedge clk) begin
    if (hold_start) begin
      out_tready <= 1'b0;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin : check_results
    coeff_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_coeffs.size() == 0) begin
        $display("%0t: result beat with none expected, coeff_out=%h range_error=%b",
                 $time, out_tdata[COEF_W-1:0], out_tuser);
        fail_count++;
      end else begin
        want = expected_coeffs.pop_front();
        if (out_tdata[COEF_W-1:0] !== want.coeff) begin
          $display("%0t: coeff_out expected %h actual %h",
                   $time, want.coeff, out_tdata[COEF_W-1:0]);
          fail_count++;
        end
        if (out_tuser !== want.range_err) begin
          $display("%0t: range_error expected %b actual %b",
                   $time, want.range_err, out_tuser);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("modular_keyswitch_accumulate test failed");
    $finish;
  end

  initial begin
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = 1'b0;
    in_tlast    = 1'b0;
    modulus_now = MOD_MIN;
    acc_value   = '0;
    acc_err     = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_modulus();
    test_modulus_extremes();
    test_run_marks();
    test_modulus_mid_run();
    test_output_backpressure();
    test_random_runs(10, 58, 1'b1);
    test_random_runs(58, 10, 1'b0);
    test_random_runs(0, 0, 1'b0);

    settle_block();
    if (fail_count == 0)
      $display("modular_keyswitch_accumulate test passed");
    else
      $display("modular_keyswitch_accumulate test failed");
    $finish;
  end

endmodule

`default_nettype wire
